>>> design/stereo_pingpong_delay_unit_macros.svh
// Assertion helpers shared by the checking code of the delay unit.
`ifndef STEREO_PINGPONG_DELAY_UNIT_MACROS_SVH
`define STEREO_PINGPONG_DELAY_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPPD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/sppd_pkg.sv
`default_nettype none
package sppd_pkg;

   // Sample and delay line geometry.
   localparam int SAMPLE_BITS   = 24;
   localparam int DELAY_DEPTH   = 131072;
   localparam int ADDR_BITS     = $clog2(DELAY_DEPTH);
   localparam int FRAC_BITS     = 8;
   localparam int DELAY_BITS    = ADDR_BITS + FRAC_BITS;

   // Feedback gain in Q0.15 and filter coefficient format Q1.22.
   localparam int FEEDBACK_GAIN = 16384;
   localparam int GAIN_SHIFT    = 15;
   localparam int COEF_BITS     = 24;
   localparam int B0_BITS       = 23;
   localparam int COEF_SHIFT    = 22;

   // Shared multiplier geometry.
   localparam int MUL_A_BITS    = SAMPLE_BITS + 4;
   localparam int MUL_B_BITS    = COEF_BITS;
   localparam int PROD_BITS     = MUL_A_BITS + MUL_B_BITS;
   localparam int SAT_IN_BITS   = PROD_BITS - COEF_SHIFT;
   localparam int BSUM_BITS     = SAMPLE_BITS + 3;

   // Configuration port.
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 5;
   localparam int DELAY_LEFT_RESET  = 3072000;
   localparam int DELAY_RIGHT_RESET = 3507200;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [COEF_BITS-1:0]   coef_type;
   typedef logic        [B0_BITS-1:0]     b0_type;
   typedef logic        [DELAY_BITS-1:0]  delay_type;
   typedef logic        [ADDR_BITS-1:0]   addr_type;
   typedef logic signed [PROD_BITS-1:0]   prod_type;

   typedef enum logic [2:0] {
      REG_DELAY_LEFT  = 3'd0,
      REG_DELAY_RIGHT = 3'd1,
      REG_HP_B0       = 3'd2,
      REG_HP_A1       = 3'd3,
      REG_HP_A2       = 3'd4,
      REG_LP_B0       = 3'd5,
      REG_LP_A1       = 3'd6,
      REG_LP_A2       = 3'd7
   } reg_index_type;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_RD0,
      PH_RD1,
      PH_MIX,
      PH_WET,
      PH_SCALE,
      PH_LPB,
      PH_LPA1,
      PH_LPA2,
      PH_LPF,
      PH_HPB,
      PH_HPA1,
      PH_HPA2,
      PH_HPF,
      PH_OUT
   } phase_type;

   typedef struct packed {
      b0_type   lp_b0;
      coef_type lp_a1;
      coef_type lp_a2;
      b0_type   hp_b0;
      coef_type hp_a1;
      coef_type hp_a2;
   } coef_set_type;

   typedef struct packed {
      phase_type phase;
      logic      wr_en;
      addr_type  wr_index;
      logic      wrapped;
   } ctrl_type;

   // Clamp a wide signed value to the sample range.
   function automatic sample_type sat_sample(input logic signed [SAT_IN_BITS-1:0] v);
      logic upper_ones;
      logic upper_zeros;
      sample_type r;
      upper_ones  = &v[SAT_IN_BITS-1:SAMPLE_BITS-1];
      upper_zeros = ~|v[SAT_IN_BITS-1:SAMPLE_BITS-1];
      if (upper_ones || upper_zeros) begin
         r = v[SAMPLE_BITS-1:0];
      end else if (v[SAT_IN_BITS-1]) begin
         r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> design/sppd_req_if.sv
`default_nettype none
interface sppd_req_if;
   logic                 valid;
   logic                 ready;
   sppd_pkg::sample_type left_in;
   sppd_pkg::sample_type right_in;

   modport source (output valid, output left_in, output right_in, input ready);
   modport sink (input valid, input left_in, input right_in, output ready);
endinterface
`default_nettype wire

>>> design/sppd_rsp_if.sv
`default_nettype none
interface sppd_rsp_if;
   logic                 valid;
   logic                 ready;
   sppd_pkg::sample_type left_out;
   sppd_pkg::sample_type right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink (input valid, input left_out, input right_out, output ready);
endinterface
`default_nettype wire

>>> design/sppd_ram.sv
`default_nettype none
module sppd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> design/sppd_lane.sv
`default_nettype none
module sppd_lane (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire sppd_pkg::ctrl_type     ctrl,
   input  wire sppd_pkg::delay_type    delay_q8,
   input  wire sppd_pkg::coef_set_type coef,
   input  wire sppd_pkg::sample_type   dry,
   input  wire sppd_pkg::sample_type   cross_wet,
   output      sppd_pkg::sample_type   wet,
   output      sppd_pkg::sample_type   out_sample
);

   localparam sppd_pkg::prod_type ROUND_CONST =
      sppd_pkg::prod_type'(1) <<< (sppd_pkg::COEF_SHIFT - 1);

   // Read position in the line, with 8 fraction bits.
   sppd_pkg::delay_type pos;
   sppd_pkg::addr_type  idx0;
   sppd_pkg::addr_type  idx1;
   sppd_pkg::addr_type  rd_addr;
   logic [sppd_pkg::FRAC_BITS-1:0] frac;
   logic                valid0;
   logic                valid1;
   logic                tap_valid;
   logic [sppd_pkg::SAMPLE_BITS-1:0] rd_data;
   sppd_pkg::sample_type tap;
   sppd_pkg::sample_type wr_sample;

   assign pos  = {ctrl.wr_index, {sppd_pkg::FRAC_BITS{1'b0}}} - delay_q8;
   assign idx0 = pos[sppd_pkg::DELAY_BITS-1:sppd_pkg::FRAC_BITS];
   assign frac = pos[sppd_pkg::FRAC_BITS-1:0];
   assign idx1 = idx0 + sppd_pkg::ADDR_BITS'(1);

   // Entries not written since reset read as zero.
   assign valid0 = ctrl.wrapped || (idx0 < ctrl.wr_index);
   assign valid1 = ctrl.wrapped || (idx1 < ctrl.wr_index);

   assign rd_addr   = (ctrl.phase == sppd_pkg::PH_RD1) ? idx1 : idx0;
   assign tap_valid = (ctrl.phase == sppd_pkg::PH_RD1) ? valid0 : valid1;
   assign tap       = tap_valid ? sppd_pkg::sample_type'(rd_data) : '0;

   sppd_ram #(
      .WIDTH(sppd_pkg::SAMPLE_BITS),
      .DEPTH(sppd_pkg::DELAY_DEPTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (ctrl.wr_en),
      .wr_addr (ctrl.wr_index),
      .wr_data (wr_sample),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Datapath registers.
   sppd_pkg::sample_type s0_ff, s0_in;
   sppd_pkg::sample_type wet_ff, wet_in;
   sppd_pkg::sample_type cur_x_ff, cur_x_in;
   sppd_pkg::prod_type   prod_ff, prod_in;
   sppd_pkg::prod_type   acc_ff, acc_in;

   // Filter history: low-pass and high-pass sections.
   sppd_pkg::sample_type lp_x1_ff, lp_x2_ff, lp_y1_ff, lp_y2_ff;
   sppd_pkg::sample_type hp_x1_ff, hp_x2_ff, hp_y1_ff, hp_y2_ff;
   sppd_pkg::sample_type lp_x1_in, lp_x2_in, lp_y1_in, lp_y2_in;
   sppd_pkg::sample_type hp_x1_in, hp_x2_in, hp_y1_in, hp_y2_in;

   logic                 is_hp;
   sppd_pkg::sample_type x1_sel, x2_sel, y1_sel, y2_sel;
   sppd_pkg::b0_type     b0_sel;
   sppd_pkg::coef_type   a1_sel, a2_sel;
   sppd_pkg::sample_type xin;
   sppd_pkg::prod_type   scaled_full;
   sppd_pkg::prod_type   interp_full;
   logic signed [sppd_pkg::SAMPLE_BITS:0] diff;
   logic signed [sppd_pkg::SAMPLE_BITS:0] wet_sum;
   logic signed [sppd_pkg::BSUM_BITS-1:0] bsum;
   logic signed [sppd_pkg::MUL_A_BITS-1:0] mul_a;
   logic signed [sppd_pkg::MUL_B_BITS-1:0] mul_b;
   sppd_pkg::prod_type   ysum;
   sppd_pkg::prod_type   yshift;
   sppd_pkg::sample_type y;

   // Pick the section that the current step works on.
   always_comb begin
      is_hp  = (ctrl.phase == sppd_pkg::PH_HPB) || (ctrl.phase == sppd_pkg::PH_HPA1) ||
               (ctrl.phase == sppd_pkg::PH_HPA2) || (ctrl.phase == sppd_pkg::PH_HPF);
      x1_sel = is_hp ? hp_x1_ff : lp_x1_ff;
      x2_sel = is_hp ? hp_x2_ff : lp_x2_ff;
      y1_sel = is_hp ? hp_y1_ff : lp_y1_ff;
      y2_sel = is_hp ? hp_y2_ff : lp_y2_ff;
      b0_sel = is_hp ? coef.hp_b0 : coef.lp_b0;
      a1_sel = is_hp ? coef.hp_a1 : coef.lp_a1;
      a2_sel = is_hp ? coef.hp_a2 : coef.lp_a2;
   end

   // Arithmetic around the shared multiplier.
   always_comb begin
      diff        = {tap[sppd_pkg::SAMPLE_BITS-1], tap} -
                    {s0_ff[sppd_pkg::SAMPLE_BITS-1], s0_ff};
      interp_full = prod_ff >>> sppd_pkg::FRAC_BITS;
      wet_sum     = {s0_ff[sppd_pkg::SAMPLE_BITS-1], s0_ff} +
                    interp_full[sppd_pkg::SAMPLE_BITS:0];
      scaled_full = prod_ff >>> sppd_pkg::GAIN_SHIFT;
      xin         = (ctrl.phase == sppd_pkg::PH_LPB) ?
                    scaled_full[sppd_pkg::SAMPLE_BITS-1:0] : cur_x_ff;
      // The high-pass middle tap is -2*b0, the low-pass one +2*b0.
      if (is_hp) begin
         bsum = sppd_pkg::BSUM_BITS'(xin) - (sppd_pkg::BSUM_BITS'(x1_sel) <<< 1) +
                sppd_pkg::BSUM_BITS'(x2_sel);
      end else begin
         bsum = sppd_pkg::BSUM_BITS'(xin) + (sppd_pkg::BSUM_BITS'(x1_sel) <<< 1) +
                sppd_pkg::BSUM_BITS'(x2_sel);
      end
      ysum        = acc_ff - prod_ff;
      yshift      = ysum >>> sppd_pkg::COEF_SHIFT;
      y           = sppd_pkg::sat_sample(yshift[sppd_pkg::SAT_IN_BITS-1:0]);
   end

   // Multiplier operands by step.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctrl.phase) inside
         sppd_pkg::PH_MIX: begin
            mul_a = sppd_pkg::MUL_A_BITS'(diff);
            mul_b = sppd_pkg::MUL_B_BITS'({1'b0, frac});
         end
         sppd_pkg::PH_SCALE: begin
            mul_a = sppd_pkg::MUL_A_BITS'(cross_wet);
            mul_b = sppd_pkg::MUL_B_BITS'(sppd_pkg::FEEDBACK_GAIN);
         end
         sppd_pkg::PH_LPB, sppd_pkg::PH_HPB: begin
            mul_a = sppd_pkg::MUL_A_BITS'(bsum);
            mul_b = {1'b0, b0_sel};
         end
         sppd_pkg::PH_LPA1, sppd_pkg::PH_HPA1: begin
            mul_a = sppd_pkg::MUL_A_BITS'(y1_sel);
            mul_b = a1_sel;
         end
         sppd_pkg::PH_LPA2, sppd_pkg::PH_HPA2: begin
            mul_a = sppd_pkg::MUL_A_BITS'(y2_sel);
            mul_b = a2_sel;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Next values of the datapath and the history.
   always_comb begin
      prod_in  = mul_a * mul_b;
      s0_in    = (ctrl.phase == sppd_pkg::PH_RD1) ? tap : s0_ff;
      wet_in   = (ctrl.phase == sppd_pkg::PH_WET) ? wet_sum[sppd_pkg::SAMPLE_BITS-1:0] : wet_ff;
      cur_x_in = cur_x_ff;
      acc_in   = acc_ff;
      lp_x1_in = lp_x1_ff;
      lp_x2_in = lp_x2_ff;
      lp_y1_in = lp_y1_ff;
      lp_y2_in = lp_y2_ff;
      hp_x1_in = hp_x1_ff;
      hp_x2_in = hp_x2_ff;
      hp_y1_in = hp_y1_ff;
      hp_y2_in = hp_y2_ff;
      case (ctrl.phase) inside
         sppd_pkg::PH_LPB: begin
            cur_x_in = xin;
         end
         sppd_pkg::PH_LPA1, sppd_pkg::PH_HPA1: begin
            acc_in = prod_ff + ROUND_CONST;
         end
         sppd_pkg::PH_LPA2, sppd_pkg::PH_HPA2: begin
            acc_in = acc_ff - prod_ff;
         end
         sppd_pkg::PH_LPF: begin
            lp_x2_in = lp_x1_ff;
            lp_x1_in = cur_x_ff;
            lp_y2_in = lp_y1_ff;
            lp_y1_in = y;
            cur_x_in = y;
         end
         sppd_pkg::PH_HPF: begin
            hp_x2_in = hp_x1_ff;
            hp_x1_in = cur_x_ff;
            hp_y2_in = hp_y1_ff;
            hp_y1_in = y;
            cur_x_in = y;
         end
         default: begin
            cur_x_in = cur_x_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      s0_ff    <= s0_in;
      wet_ff   <= wet_in;
      cur_x_ff <= cur_x_in;
      acc_ff   <= acc_in;
   end

   // Filter history starts cleared.
   always_ff @(posedge clock) begin
      if (reset) begin
         lp_x1_ff <= '0;
         lp_x2_ff <= '0;
         lp_y1_ff <= '0;
         lp_y2_ff <= '0;
         hp_x1_ff <= '0;
         hp_x2_ff <= '0;
         hp_y1_ff <= '0;
         hp_y2_ff <= '0;
      end else begin
         lp_x1_ff <= lp_x1_in;
         lp_x2_ff <= lp_x2_in;
         lp_y1_ff <= lp_y1_in;
         lp_y2_ff <= lp_y2_in;
         hp_x1_ff <= hp_x1_in;
         hp_x2_ff <= hp_x2_in;
         hp_y1_ff <= hp_y1_in;
         hp_y2_ff <= hp_y2_in;
      end
   end

   // Line write value and lane output.
   assign wr_sample  = sppd_pkg::sat_sample(sppd_pkg::SAT_IN_BITS'(dry) +
                                            sppd_pkg::SAT_IN_BITS'(cur_x_ff));
   assign out_sample = sppd_pkg::sat_sample(sppd_pkg::SAT_IN_BITS'(dry) +
                                            sppd_pkg::SAT_IN_BITS'(wet_ff));
   assign wet        = wet_ff;

endmodule
`default_nettype wire

>>> design/stereo_pingpong_delay_unit.sv
// An accepted input beat runs the read, interpolation, scaling, low-pass and
// high-pass steps to the rsp_bus result and no new pair is taken until it is
// loaded. Each lane shares one multiplier over interpolation, scaling and both
// biquads. Synchronous active-high reset clears the sequencer, filter history,
// write index, coefs; delays preset; lines not cleared, read zero until written.
`default_nettype none
`include "stereo_pingpong_delay_unit_macros.svh"
module stereo_pingpong_delay_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   sppd_req_if.sink                                  req_bus,
   sppd_rsp_if.source                                rsp_bus,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [sppd_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [sppd_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output      logic [sppd_pkg::CSR_DATA_BITS-1:0]   prdata,
   output      logic                                 pready
);

   // Configuration registers.
   sppd_pkg::delay_type    delay_left_ff, delay_left_in;
   sppd_pkg::delay_type    delay_right_ff, delay_right_in;
   sppd_pkg::coef_set_type coef_ff, coef_in;
   sppd_pkg::reg_index_type csr_index;
   logic                   csr_write;

   assign pready    = 1'b1;
   assign csr_index = sppd_pkg::reg_index_type'(paddr[sppd_pkg::CSR_ADDR_BITS-1:2]);
   assign csr_write = psel && penable && pwrite;

   // Register write decode.
   always_comb begin
      delay_left_in  = delay_left_ff;
      delay_right_in = delay_right_ff;
      coef_in        = coef_ff;
      if (csr_write) begin
         unique case (csr_index)
            sppd_pkg::REG_DELAY_LEFT:  delay_left_in  = pwdata[sppd_pkg::DELAY_BITS-1:0];
            sppd_pkg::REG_DELAY_RIGHT: delay_right_in = pwdata[sppd_pkg::DELAY_BITS-1:0];
            sppd_pkg::REG_HP_B0:       coef_in.hp_b0  = pwdata[sppd_pkg::B0_BITS-1:0];
            sppd_pkg::REG_HP_A1:       coef_in.hp_a1  = pwdata[sppd_pkg::COEF_BITS-1:0];
            sppd_pkg::REG_HP_A2:       coef_in.hp_a2  = pwdata[sppd_pkg::COEF_BITS-1:0];
            sppd_pkg::REG_LP_B0:       coef_in.lp_b0  = pwdata[sppd_pkg::B0_BITS-1:0];
            sppd_pkg::REG_LP_A1:       coef_in.lp_a1  = pwdata[sppd_pkg::COEF_BITS-1:0];
            sppd_pkg::REG_LP_A2:       coef_in.lp_a2  = pwdata[sppd_pkg::COEF_BITS-1:0];
            default:                   coef_in        = coef_ff;
         endcase
      end
   end

   // Register read mux.
   always_comb begin
      unique case (csr_index)
         sppd_pkg::REG_DELAY_LEFT:  prdata = sppd_pkg::CSR_DATA_BITS'(delay_left_ff);
         sppd_pkg::REG_DELAY_RIGHT: prdata = sppd_pkg::CSR_DATA_BITS'(delay_right_ff);
         sppd_pkg::REG_HP_B0:       prdata = sppd_pkg::CSR_DATA_BITS'(coef_ff.hp_b0);
         sppd_pkg::REG_HP_A1:       prdata = sppd_pkg::CSR_DATA_BITS'(coef_ff.hp_a1);
         sppd_pkg::REG_HP_A2:       prdata = sppd_pkg::CSR_DATA_BITS'(coef_ff.hp_a2);
         sppd_pkg::REG_LP_B0:       prdata = sppd_pkg::CSR_DATA_BITS'(coef_ff.lp_b0);
         sppd_pkg::REG_LP_A1:       prdata = sppd_pkg::CSR_DATA_BITS'(coef_ff.lp_a1);
         sppd_pkg::REG_LP_A2:       prdata = sppd_pkg::CSR_DATA_BITS'(coef_ff.lp_a2);
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_left_ff  <= sppd_pkg::DELAY_BITS'(sppd_pkg::DELAY_LEFT_RESET);
         delay_right_ff <= sppd_pkg::DELAY_BITS'(sppd_pkg::DELAY_RIGHT_RESET);
         coef_ff        <= '0;
      end else begin
         delay_left_ff  <= delay_left_in;
         delay_right_ff <= delay_right_in;
         coef_ff        <= coef_in;
      end
   end

   // Sequencer state, write index and result slot.
   sppd_pkg::phase_type  state_ff, state_in;
   sppd_pkg::addr_type   wr_index_ff, wr_index_in;
   logic                 wrapped_ff, wrapped_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   sppd_pkg::sample_type dry_left_ff, dry_left_in;
   sppd_pkg::sample_type dry_right_ff, dry_right_in;
   sppd_pkg::sample_type left_out_ff, left_out_in;
   sppd_pkg::sample_type right_out_ff, right_out_in;
   logic                 in_beat;
   logic                 out_load;
   sppd_pkg::ctrl_type   ctrl;
   sppd_pkg::sample_type wet_left;
   sppd_pkg::sample_type wet_right;
   sppd_pkg::sample_type lane_left_out;
   sppd_pkg::sample_type lane_right_out;

   assign req_bus.ready = (state_ff == sppd_pkg::PH_IDLE);
   assign in_beat       = req_bus.valid && req_bus.ready;
   assign out_load      = (state_ff == sppd_pkg::PH_OUT) && (!rsp_valid_ff || rsp_bus.ready);

   // Next state and step outputs.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sppd_pkg::PH_IDLE:  if (in_beat) state_in = sppd_pkg::PH_RD0;
         sppd_pkg::PH_RD0:   state_in = sppd_pkg::PH_RD1;
         sppd_pkg::PH_RD1:   state_in = sppd_pkg::PH_MIX;
         sppd_pkg::PH_MIX:   state_in = sppd_pkg::PH_WET;
         sppd_pkg::PH_WET:   state_in = sppd_pkg::PH_SCALE;
         sppd_pkg::PH_SCALE: state_in = sppd_pkg::PH_LPB;
         sppd_pkg::PH_LPB:   state_in = sppd_pkg::PH_LPA1;
         sppd_pkg::PH_LPA1:  state_in = sppd_pkg::PH_LPA2;
         sppd_pkg::PH_LPA2:  state_in = sppd_pkg::PH_LPF;
         sppd_pkg::PH_LPF:   state_in = sppd_pkg::PH_HPB;
         sppd_pkg::PH_HPB:   state_in = sppd_pkg::PH_HPA1;
         sppd_pkg::PH_HPA1:  state_in = sppd_pkg::PH_HPA2;
         sppd_pkg::PH_HPA2:  state_in = sppd_pkg::PH_HPF;
         sppd_pkg::PH_HPF:   state_in = sppd_pkg::PH_OUT;
         sppd_pkg::PH_OUT:   if (out_load) state_in = sppd_pkg::PH_IDLE;
         default:            state_in = sppd_pkg::PH_IDLE;
      endcase

      ctrl.phase    = state_ff;
      ctrl.wr_en    = out_load;
      ctrl.wr_index = wr_index_ff;
      ctrl.wrapped  = wrapped_ff;

      wr_index_in  = out_load ? wr_index_ff + sppd_pkg::ADDR_BITS'(1) : wr_index_ff;
      wrapped_in   = wrapped_ff || (out_load && (&wr_index_ff));
      rsp_valid_in = out_load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
      dry_left_in  = in_beat ? req_bus.left_in : dry_left_ff;
      dry_right_in = in_beat ? req_bus.right_in : dry_right_ff;
      left_out_in  = out_load ? lane_left_out : left_out_ff;
      right_out_in = out_load ? lane_right_out : right_out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sppd_pkg::PH_IDLE;
         wr_index_ff  <= '0;
         wrapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_index_ff  <= wr_index_in;
         wrapped_ff   <= wrapped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dry_left_ff  <= dry_left_in;
      dry_right_ff <= dry_right_in;
      left_out_ff  <= left_out_in;
      right_out_ff <= right_out_in;
   end

   // Two lanes; each feeds its line from the other lane's wet sample.
   sppd_lane u_lane_left (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .delay_q8   (delay_left_ff),
      .coef       (coef_ff),
      .dry        (dry_left_ff),
      .cross_wet  (wet_right),
      .wet        (wet_left),
      .out_sample (lane_left_out)
   );

   sppd_lane u_lane_right (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .delay_q8   (delay_right_ff),
      .coef       (coef_ff),
      .dry        (dry_right_ff),
      .cross_wet  (wet_left),
      .wet        (wet_right),
      .out_sample (lane_right_out)
   );

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.left_out  = left_out_ff;
   assign rsp_bus.right_out = right_out_ff;

   // Checks on the sequencer and the result slot.
   `SPPD_ASSERT_NEXT(a_accept_starts, clock, reset, in_beat, state_ff == sppd_pkg::PH_RD0, "accepted beat did not start the read step")
   `SPPD_ASSERT_NEXT(a_out_waits, clock, reset, (state_ff == sppd_pkg::PH_OUT) && rsp_bus.valid && !rsp_bus.ready, state_ff == sppd_pkg::PH_OUT, "result overwrote a beat still waiting")
   `SPPD_ASSERT_NEXT(a_load_shows, clock, reset, out_load, rsp_bus.valid && (state_ff == sppd_pkg::PH_IDLE), "loaded result not presented")
   `SPPD_ASSERT_SAME(a_busy_blocks, clock, reset, rsp_bus.valid && (state_ff == sppd_pkg::PH_OUT), !out_load || rsp_bus.ready, "result slot reloaded while full")

endmodule
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps

// Scoreboard: carries its own copy of both delay lines, the filter history and
// the register set, and predicts one stereo output pair per accepted input beat.
class delay_scoreboard;
   int              left_line[sppd_pkg::DELAY_DEPTH];
   int              right_line[sppd_pkg::DELAY_DEPTH];
   bit [16:0]       wr_pos;
   longint          hist[16];
   bit [24:0]       dly_l, dly_r;
   longint          hp_b0, hp_a1, hp_a2, lp_b0, lp_a1, lp_a2;
   sppd_pkg::sample_type exp_left[$];
   sppd_pkg::sample_type exp_right[$];
   int              failures;
   int              pairs_in;
   int              pairs_out;

   function new();
      dly_l = 25'(sppd_pkg::DELAY_LEFT_RESET);
      dly_r = 25'(sppd_pkg::DELAY_RIGHT_RESET);
   endfunction

   function longint clamp(longint x);
      if (x > 64'sd8388607) return 64'sd8388607;
      if (x < -64'sd8388608) return -64'sd8388608;
      return x;
   endfunction

   // Linear interpolation between the two taps around the fractional position.
   function longint interp(bit right_side, bit [24:0] d);
      bit [24:0] p;
      bit [16:0] i0, i1;
      longint    f, s0, s1;
      p  = {wr_pos, 8'd0} - d;
      i0 = p[24:8];
      i1 = i0 + 17'd1;
      f  = p[7:0];
      s0 = right_side ? right_line[i0] : left_line[i0];
      s1 = right_side ? right_line[i1] : left_line[i1];
      return s0 + ((f * (s1 - s0)) >>> 8);
   endfunction

   // Direct form I biquad with round-half-up and saturation.
   function longint biquad(int base, longint x, longint b0, longint b1,
                           longint a1, longint a2);
      longint acc, y;
      acc = b0 * x + b1 * hist[base] + b0 * hist[base+1]
            - a1 * hist[base+2] - a2 * hist[base+3];
      y = clamp((acc + 64'sd2097152) >>> 22);
      hist[base+1] = hist[base];
      hist[base]   = x;
      hist[base+3] = hist[base+2];
      hist[base+2] = y;
      return y;
   endfunction

   function longint shape_feedback(int base, longint wet);
      longint x, y;
      x = (wet * sppd_pkg::FEEDBACK_GAIN) >>> sppd_pkg::GAIN_SHIFT;
      y = biquad(base, x, lp_b0, 2 * lp_b0, lp_a1, lp_a2);
      return biquad(base + 4, y, hp_b0, -2 * hp_b0, hp_a1, hp_a2);
   endfunction

   function void set_reg(sppd_pkg::reg_index_type idx, longint v);
      case (idx)
         sppd_pkg::REG_DELAY_LEFT:  dly_l = v[24:0];
         sppd_pkg::REG_DELAY_RIGHT: dly_r = v[24:0];
         sppd_pkg::REG_HP_B0:       hp_b0 = v[22:0];
         sppd_pkg::REG_HP_A1:       hp_a1 = $signed(v[23:0]);
         sppd_pkg::REG_HP_A2:       hp_a2 = $signed(v[23:0]);
         sppd_pkg::REG_LP_B0:       lp_b0 = v[22:0];
         sppd_pkg::REG_LP_A1:       lp_a1 = $signed(v[23:0]);
         sppd_pkg::REG_LP_A2:       lp_a2 = $signed(v[23:0]);
         default: ;
      endcase
   endfunction

   // The lines are read before the current position is written.
   function void note_pair(sppd_pkg::sample_type l, sppd_pkg::sample_type r);
      longint dl, dr, wet_l, wet_r, fb_l, fb_r;
      dl    = l;
      dr    = r;
      wet_l = interp(1'b0, dly_l);
      wet_r = interp(1'b1, dly_r);
      fb_l  = shape_feedback(0, wet_r);
      fb_r  = shape_feedback(8, wet_l);
      left_line[wr_pos]  = int'(clamp(dl + fb_l));
      right_line[wr_pos] = int'(clamp(dr + fb_r));
      exp_left.push_back(sppd_pkg::sample_type'(clamp(dl + wet_l)));
      exp_right.push_back(sppd_pkg::sample_type'(clamp(dr + wet_r)));
      wr_pos++;
      pairs_in++;
   endfunction

   function void check_pair(sppd_pkg::sample_type l, sppd_pkg::sample_type r);
      sppd_pkg::sample_type el, er;
      if (exp_left.size() == 0) begin
         $error("unexpected result beat left_out %0d right_out %0d", l, r);
         failures++;
         return;
      end
      el = exp_left.pop_front();
      er = exp_right.pop_front();
      pairs_out++;
      if (l !== el) begin
         $error("left_out expected %0d actual %0d", el, l);
         failures++;
      end
      if (r !== er) begin
         $error("right_out expected %0d actual %0d", er, r);
         failures++;
      end
   endfunction

   function int pending();
      return exp_left.size();
   endfunction
endclass

module tb_top;

   logic clock;
   logic reset;
   logic psel, penable, pwrite;
   logic [sppd_pkg::CSR_ADDR_BITS-1:0] paddr;
   logic [sppd_pkg::CSR_DATA_BITS-1:0] pwdata;
   logic [sppd_pkg::CSR_DATA_BITS-1:0] prdata;
   logic pready;

   sppd_req_if req_bus();
   sppd_rsp_if rsp_bus();

   stereo_pingpong_delay_unit dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   delay_scoreboard sb = new();
   int tx_idle_pct;
   int rx_idle_pct;
   int hold_left;
   longint cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset           = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.left_in  = '0;
      req_bus.right_in = '0;
      rsp_bus.ready    = 1'b0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // Cycle counter guards against a hung block.
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > 2000000) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Result side: random back-pressure plus an optional long hold-off.
   initial begin
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            sb.check_pair(rsp_bus.left_out, rsp_bus.right_out);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Setup phase, then access phase, then idle before the next transfer.
   task automatic write_reg(sppd_pkg::reg_index_type idx, longint v);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= sppd_pkg::CSR_ADDR_BITS'(idx * 4);
      pwdata  <= v[31:0];
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_reg(idx, v);
      @(posedge clock);
   endtask

   // Offer one beat; valid stays high if the next beat follows directly.
   task automatic send_pair(sppd_pkg::sample_type l, sppd_pkg::sample_type r);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.left_in  <= l;
      req_bus.right_in <= r;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_pair(l, r);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic sppd_pkg::sample_type pick_sample();
      case ($urandom_range(9))
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         2: return sppd_pkg::sample_type'($urandom_range(15)) - 24'sd8;
         default: return sppd_pkg::sample_type'($urandom);
      endcase
   endfunction

   function automatic longint rand_coef();
      return $signed(24'($urandom));
   endfunction

   // Write the full register set; phases 1 to 5 each pick a corner, 7 repeats 3.
   task automatic configure(int k);
      longint d_l, d_r, lb, la1, la2, hb, ha1, ha2;
      d_l = $urandom_range(200 * 256);
      d_r = $urandom_range(200 * 256);
      lb = 283000; la1 = -4794000; la2 = 1732000;
      hb = 2676000; ha1 = -4794000; ha2 = 1732000;
      case (k)
         1: begin
            d_l = 0; d_r = 0;
         end
         2: begin
            d_l = 33553920; d_r = 25'($urandom);
            lb = 0; hb = $urandom_range(4194304); ha1 = rand_coef(); ha2 = rand_coef();
         end
         3, 7: begin
            lb = $urandom_range(4194304); la1 = rand_coef(); la2 = rand_coef();
            hb = $urandom_range(4194304); ha1 = rand_coef(); ha2 = rand_coef();
         end
         4: begin
            lb = 4194304; la1 = -8388608; la2 = 8388607;
            hb = 4194304; ha1 = -8388608; ha2 = 8388607;
         end
         5: begin
            lb = $urandom_range(4194304); la1 = 8388607; la2 = -8388608;
            hb = $urandom_range(4194304); ha1 = 8388607; ha2 = -8388608;
         end
         default: ;
      endcase
      write_reg(sppd_pkg::REG_DELAY_LEFT, d_l);
      write_reg(sppd_pkg::REG_DELAY_RIGHT, d_r);
      write_reg(sppd_pkg::REG_LP_B0, lb);
      write_reg(sppd_pkg::REG_LP_A1, la1);
      write_reg(sppd_pkg::REG_LP_A2, la2);
      write_reg(sppd_pkg::REG_HP_B0, hb);
      write_reg(sppd_pkg::REG_HP_A1, ha1);
      write_reg(sppd_pkg::REG_HP_A2, ha2);
   endtask

   // Main sequence: directed corners, then randomized phases.
   initial begin
      sppd_pkg::sample_type corner[10];
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      corner = '{24'sh7FFFFF, 24'sh800000, 24'sd0, -24'sd1, 24'sd1,
                 24'sh555555, 24'shAAAAAA, 24'sh400000, 24'shC00000, 24'sd255};
      @(negedge reset);
      @(posedge clock);

      // Muted feedback at reset values, then hard saturating filters.
      for (int i = 0; i < 6; i++) send_pair(corner[i], corner[9 - i]);
      wait_idle();
      write_reg(sppd_pkg::REG_DELAY_LEFT, 3 * 256 + 128);
      write_reg(sppd_pkg::REG_DELAY_RIGHT, 1 * 256);
      write_reg(sppd_pkg::REG_LP_B0, 4194304);
      write_reg(sppd_pkg::REG_LP_A1, -8388608);
      write_reg(sppd_pkg::REG_LP_A2, 8388607);
      write_reg(sppd_pkg::REG_HP_B0, 4194304);
      write_reg(sppd_pkg::REG_HP_A1, 0);
      write_reg(sppd_pkg::REG_HP_A2, 0);
      for (int i = 0; i < 10; i++) send_pair(corner[i], corner[(i + 3) % 10]);
      wait_idle();
      // Zero delay reads the sample about to be overwritten.
      write_reg(sppd_pkg::REG_DELAY_LEFT, 0);
      write_reg(sppd_pkg::REG_DELAY_RIGHT, 33553920);
      for (int i = 0; i < 8; i++) send_pair(corner[i], corner[i + 1]);
      wait_idle();

      for (int k = 0; k < 8; k++) begin
         tx_idle_pct = (k < 3) ? 29 : (k < 6) ? 73 : 0;
         rx_idle_pct = (k < 3) ? 73 : (k < 6) ? 29 : 0;
         configure(k);
         if (k == 6) hold_left = 600;
         for (int n = 0; n < 130; n++) begin
            send_pair(pick_sample(), pick_sample());
         end
         wait_idle();
      end

      $display("Covered %0d stereo beats over 11 register settings, results checked: %0d.",
               sb.pairs_in, sb.pairs_out);
      $display("Settings spanned zero, maximum and random delays, muted and unstable filters.");
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
